// ===== src/umpq_pkg.sv =====
// shared types and constants of the unsorted max priority queue
`default_nettype none

package umpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic load;
      logic classify;
      logic write_tail;
      logic scan_start;
      logic scan_read;
      logic shift_start;
      logic shift_read;
      logic dec_count;
      logic result_load;
   } umpq_cmd_type;

   typedef struct packed {
      logic op_is_deq;
      logic is_full;
      logic is_empty;
      logic scan_last;
      logic shift_done;
      logic out_free;
   } umpq_stat_type;

endpackage

`default_nettype wire

// ===== src/umpq_if.sv =====
// request and response channel interfaces
`default_nettype none

interface umpq_req_if import umpq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink (input valid, input opcode, input item_value, output ready);
endinterface

interface umpq_rsp_if import umpq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] removed_value;
   logic [COUNT_W-1:0]        entry_count;

   modport source (output valid, output status, output removed_value, output entry_count,
                   input ready);
   modport sink (input valid, input status, input removed_value, input entry_count,
                 output ready);
endinterface

`default_nettype wire

// ===== src/umpq_datapath.sv =====
// entry store, scan and compaction datapath and result register
`default_nettype none

module umpq_datapath import umpq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire umpq_cmd_type              cmd,
   output      umpq_stat_type             stat,
   input  wire logic                      req_opcode,
   input  wire logic signed [VALUE_W-1:0] req_item_value,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [STATUS_W-1:0]       rsp_status,
   output      logic signed [VALUE_W-1:0] rsp_removed_value,
   output      logic [COUNT_W-1:0]        rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic                      op_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [STATUS_W-1:0]       code_ff, code_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          ptr_ff, ptr_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      rd_move_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic [VALUE_W-1:0]        rd_data_ff;
   logic signed [VALUE_W-1:0] best_val_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_removed_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic                 mem_rd_en;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [VALUE_W-1:0]   mem_wr_data;
   logic                 take_best;
   logic [CNT_W-1:0]     count_less1;

   assign count_less1 = count_ff - CNT_W'(1);

   assign mem_rd_en   = cmd.scan_read || cmd.shift_read;
   assign mem_wr_en   = cmd.write_tail || (rd_vld_ff && rd_move_ff);
   assign mem_wr_addr = cmd.write_tail ? count_ff[IDX_W-1:0] : rd_idx_ff - IDX_W'(1);
   assign mem_wr_data = cmd.write_tail ? VALUE_W'(val_ff) : rd_data_ff;
   assign take_best   = rd_vld_ff && !rd_move_ff &&
                        ((rd_idx_ff == '0) || ($signed(rd_data_ff) > best_val_ff));

   // entry store
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      code_in = code_ff;
      if (cmd.classify) begin
         if (op_ff == OP_ENQUEUE) begin
            code_in = stat.is_full ? ST_FULL : ST_DONE;
         end else begin
            code_in = stat.is_empty ? ST_EMPTY : ST_DONE;
         end
      end

      count_in = count_ff;
      if (cmd.write_tail) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_less1;
      end

      ptr_in = ptr_ff;
      if (cmd.scan_start) begin
         ptr_in = '0;
      end else if (cmd.shift_start) begin
         ptr_in = CNT_W'(best_idx_ff) + CNT_W'(1);
      end else if (mem_rd_en) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end

      rd_vld_in = mem_rd_en;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= req_item_value;
      end
      code_ff <= code_in;
      ptr_ff  <= ptr_in;
      if (mem_rd_en) begin
         rd_move_ff <= cmd.shift_read;
         rd_idx_ff  <= ptr_ff[IDX_W-1:0];
      end
      if (take_best) begin
         best_val_ff <= $signed(rd_data_ff);
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.result_load) begin
         rsp_status_ff  <= code_ff;
         rsp_removed_ff <= ((op_ff == OP_DEQUEUE) && (code_ff == ST_DONE)) ? best_val_ff : '0;
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   assign stat.op_is_deq  = (op_ff == OP_DEQUEUE);
   assign stat.is_full    = (count_ff == CNT_W'(CAPACITY));
   assign stat.is_empty   = (count_ff == '0);
   assign stat.scan_last  = (ptr_ff == count_less1);
   assign stat.shift_done = (ptr_ff >= count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
      ((count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("entry count moved by more than one");

   a_no_tail_during_move : assert property (@(posedge clock) disable iff (reset)
      cmd.write_tail |-> !rd_vld_ff)
      else $error("tail write collides with a pending read");

endmodule

`default_nettype wire

// ===== src/umpq_ctrl.sv =====
// sequencing state machine of the priority queue
`default_nettype none

module umpq_ctrl import umpq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire umpq_stat_type stat,
   output      umpq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE        = 3'd0;
   localparam logic [2:0] S_CLASSIFY    = 3'd1;
   localparam logic [2:0] S_SCAN        = 3'd2;
   localparam logic [2:0] S_SCAN_WAIT   = 3'd3;
   localparam logic [2:0] S_SHIFT_START = 3'd4;
   localparam logic [2:0] S_SHIFT       = 3'd5;
   localparam logic [2:0] S_FINISH      = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (!stat.op_is_deq) begin
               cmd.write_tail = !stat.is_full;
               state_in       = S_FINISH;
            end else if (stat.is_empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            state_in = S_SHIFT_START;
         end
         S_SHIFT_START: begin
            cmd.shift_start = 1'b1;
            state_in        = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.shift_done) begin
               cmd.dec_count = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.shift_read = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_memory_op : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_tail, cmd.scan_read, cmd.shift_read}))
      else $error("more than one store operation in a cycle");

   a_load_then_classify : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.classify)
      else $error("accepted item not classified next cycle");

   a_result_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> stat.out_free)
      else $error("result loaded over a waiting result");

endmodule

`default_nettype wire

// ===== src/unsorted_max_priority_queue_top.sv =====
// top level of the unsorted max priority queue
//
// req_ch carries one item per transfer: opcode (enqueue or dequeue) and a
// signed 32-bit item_value. rsp_ch returns exactly one result per item:
// status, removed_value and the entry count after the item.
// Entries are kept packed in insertion order in a single-port-read memory.
// An enqueue writes the tail in the classify state, then the last state loads
// the result register; the next transfer is taken back in the idle state.
// A dequeue reads every held entry, one a cycle, keeping the first largest,
// then moves the younger entries down one place, one a cycle, and the last
// state loads the result. Full or empty cases go from the classify state
// straight to the last state, as an enqueue does.
// One item is worked on at a time; the next transfer is taken once the result
// sits in the output register, while that result still waits for rsp_ch.ready.
// A stalled receiver holds the result; a later result waits in the last state.
// Synchronous reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module unsorted_max_priority_queue_top import umpq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   umpq_req_if.sink   req_ch,
   umpq_rsp_if.source rsp_ch
);

   umpq_cmd_type  cmd;
   umpq_stat_type stat;

   umpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   umpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_ch.opcode),
      .req_item_value    (req_ch.item_value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_removed_value (rsp_ch.removed_value),
      .rsp_entry_count   (rsp_ch.entry_count)
   );

endmodule

`default_nettype wire
